@@ rtl/kau_pkg.sv @@
// Shared types and constants for the k-means assign/update block.
`default_nettype none
package kau_pkg;

   localparam int DEF_MAX_CENTERS     = 8;
   localparam int DEF_MAX_DIMS        = 8;
   localparam int DEF_MAX_POINTS_LOG2 = 20;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;
   localparam int DIST_W     = 38;
   localparam int ERR_W      = 58;
   localparam int COORD_W    = 16;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_POINT  = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CENTERS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIMS    = 1'b1;

   localparam logic KIND_POINT  = 1'b0;
   localparam logic KIND_CENTER = 1'b1;

   typedef struct packed {
      logic [1:0]                op;
      logic [2:0]                center_index;
      logic [2:0]                dim_index;
      logic signed [COORD_W-1:0] coord_value;
   } req_payload_type;

   typedef struct packed {
      logic                      kind;
      logic [2:0]                out_center;
      logic [2:0]                out_dim;
      logic signed [COORD_W-1:0] new_coord;
      logic [DIST_W-1:0]         min_distance;
      logic                      empty_cluster;
      logic [ERR_W-1:0]          total_error;
      logic                      last;
   } rsp_payload_type;

   // Classified command handed from the front to the back end
   typedef struct packed {
      logic                      load;
      logic                      point;
      logic                      finish;
      logic                      first;
      logic                      last_dim;
      logic [2:0]                center;
      logic [2:0]                dim;
      logic signed [COORD_W-1:0] value;
   } cmd_type;

endpackage
`default_nettype wire

@@ rtl/kau_stream_if.sv @@
// Valid/ready stream interface carrying one payload beat.
`default_nettype none
interface kau_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/kau_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kau_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

@@ rtl/kau_front.sv @@
// Front end: accepts request beats, classifies them and queues commands.
`default_nettype none
module kau_front #(
   parameter int MAX_CENTERS = kau_pkg::DEF_MAX_CENTERS,
   parameter int MAX_DIMS    = kau_pkg::DEF_MAX_DIMS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [3:0]               nd_eff,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire kau_pkg::req_payload_type in_payload,
   output logic                          cmd_valid,
   output kau_pkg::cmd_type              cmd,
   input  wire logic                     cmd_pop
);
   import kau_pkg::*;

   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic       keep, push;

   always_comb begin
      cls          = '0;
      cls.center   = in_payload.center_index;
      cls.dim      = in_payload.dim_index;
      cls.value    = in_payload.coord_value;
      cls.first    = (in_payload.dim_index == 3'd0);
      cls.last_dim = ({1'b0, in_payload.dim_index} == nd_eff - 4'd1);
      case (in_payload.op)
         OP_LOAD: cls.load = (int'(in_payload.center_index) < MAX_CENTERS) &&
                             (int'(in_payload.dim_index) < MAX_DIMS);
         OP_POINT: cls.point = ({1'b0, in_payload.dim_index} < nd_eff);
         OP_FINISH: cls.finish = 1'b1;
         default: cls = cls;
      endcase
      keep = cls.load | cls.point | cls.finish;
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign push      = in_valid && in_ready && keep;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      q_in  = q_ff;
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (push) begin
         q_in[wp_ff] = cls;
         wp_in       = ~wp_ff;
      end
      // drop beats that do nothing: unused op, out-of-range index
      if (cmd_pop) begin
         rp_in = ~rp_ff;
      end
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/kau_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module kau_div #(
   parameter int NW = 37,
   parameter int DW = 21
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic [NW-1:0]      quotient
);
   localparam int CNTW = $clog2(NW + 1);

   logic [NW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   dvs_ff, dvs_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            done_ff, done_in;
   logic [DW:0]     trial;
   logic            qbit;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NW-1]};
      qbit    = (trial >= {1'b0, dvs_ff});
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNTW'(NW);
      end else if (cnt_ff != '0) begin
         rem_in  = qbit ? DW'(trial - {1'b0, dvs_ff}) : trial[DW-1:0];
         quo_in  = {quo_ff[NW-2:0], qbit};
         cnt_in  = cnt_ff - CNTW'(1);
         done_in = (cnt_ff == CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

@@ rtl/kau_core.sv @@
// Back end: distance accumulation, nearest-center search, sums and center update.
`default_nettype none
module kau_core #(
   parameter int MAX_CENTERS     = kau_pkg::DEF_MAX_CENTERS,
   parameter int MAX_DIMS        = kau_pkg::DEF_MAX_DIMS,
   parameter int MAX_POINTS_LOG2 = kau_pkg::DEF_MAX_POINTS_LOG2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [3:0]       k_eff,
   input  wire logic [3:0]       nd_eff,
   input  wire logic             cmd_valid,
   input  wire kau_pkg::cmd_type cmd,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output kau_pkg::rsp_payload_type rsp_payload
);
   import kau_pkg::*;

   localparam int DEPTH = MAX_CENTERS * MAX_DIMS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = MAX_POINTS_LOG2 + 17;
   localparam int CW    = MAX_POINTS_LOG2 + 1;
   localparam int CIW   = $clog2(MAX_CENTERS);
   localparam int DIW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam logic [CW-1:0] COUNT_MAX = CW'(1) << MAX_POINTS_LOG2;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CRD   = 4'd1;
   localparam logic [3:0] S_DIFF  = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_ACC   = 4'd4;
   localparam logic [3:0] S_MIN   = 4'd5;
   localparam logic [3:0] S_SRD   = 4'd6;
   localparam logic [3:0] S_SWR   = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;
   localparam logic [3:0] S_FRD   = 4'd9;
   localparam logic [3:0] S_FCHK  = 4'd10;
   localparam logic [3:0] S_FDIV  = 4'd11;
   localparam logic [3:0] S_FEMIT = 4'd12;
   localparam logic [3:0] S_FCLR  = 4'd13;

   function automatic logic [AW-1:0] addr_of(logic [2:0] c, logic [2:0] d);
      return AW'(int'(c) * MAX_DIMS + int'(d));
   endfunction

   logic [3:0]                state_ff, state_in;
   cmd_type                   item_ff, item_in;
   logic [2:0]                c_ff, c_in, d_ff, d_in, best_ff, best_in;
   logic [DIST_W-1:0]         bd_ff, bd_in;
   logic signed [16:0]        diff_ff, diff_in;
   logic [33:0]               sq_ff, sq_in;
   logic [DIST_W-1:0]         part_ff [MAX_CENTERS];
   logic [DIST_W-1:0]         part_in [MAX_CENTERS];
   logic signed [COORD_W-1:0] pbuf_ff [MAX_DIMS];
   logic signed [COORD_W-1:0] pbuf_in [MAX_DIMS];
   logic [MAX_DIMS-1:0]       pval_ff, pval_in;
   logic [DEPTH-1:0]          sval_ff, sval_in;
   logic [CW-1:0]             cnt_ff [MAX_CENTERS];
   logic [CW-1:0]             cnt_in [MAX_CENTERS];
   logic [ERR_W-1:0]          err_ff, err_in;
   logic                      neg_ff, neg_in, empty_ff, empty_in;
   logic signed [COORD_W-1:0] nc_ff, nc_in;
   logic                      rv_ff, rv_in;
   rsp_payload_type           rp_ff, rp_in;

   logic                      cen_we;
   logic [AW-1:0]             cen_waddr, cen_raddr;
   logic [COORD_W-1:0]        cen_wdata, cen_rdata;
   logic                      sum_we;
   logic [AW-1:0]             sum_waddr, sum_raddr;
   logic [SW-1:0]             sum_wdata, sum_rdata;
   logic                      div_start, div_done;
   logic [SW-1:0]             div_dividend, div_q;

   logic                      out_free, c_last, d_last;
   logic [AW-1:0]             addr_cd, addr_bd, addr_ci;
   logic [DIST_W-1:0]         bd_new;
   logic [ERR_W:0]            err_sum;
   logic signed [SW-1:0]      sval_rd, quo_s;
   logic signed [COORD_W-1:0] pv;
   logic [CIW-1:0]            ci, bi;
   logic [DIW-1:0]            di;

   kau_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_center_ram (
      .clock(clock), .we(cen_we), .waddr(cen_waddr), .wdata(cen_wdata),
      .raddr(cen_raddr), .rdata(cen_rdata)
   );

   kau_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_sum_ram (
      .clock(clock), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
      .raddr(sum_raddr), .rdata(sum_rdata)
   );

   kau_div #(.NW(SW), .DW(CW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(cnt_ff[ci]), .done(div_done), .quotient(div_q)
   );

   assign out_free = !rv_ff || rsp_ready;
   assign c_last   = ({1'b0, c_ff} == k_eff - 4'd1);
   assign d_last   = ({1'b0, d_ff} == nd_eff - 4'd1);
   assign addr_cd  = addr_of(c_ff, d_ff);
   assign addr_bd  = addr_of(best_ff, d_ff);
   assign addr_ci  = addr_of(c_ff, item_ff.dim);
   assign ci       = c_ff[CIW-1:0];
   assign bi       = best_ff[CIW-1:0];
   assign di       = d_ff[DIW-1:0];
   assign bd_new   = ((c_ff == 3'd0) || (part_ff[ci] < bd_ff)) ? part_ff[ci] : bd_ff;
   assign err_sum  = {1'b0, err_ff} + (ERR_W + 1)'(bd_new);
   assign sval_rd  = sval_ff[addr_cd] ? sum_rdata : '0;
   assign quo_s    = neg_ff ? -div_q : div_q;
   assign pv       = pval_ff[di] ? pbuf_ff[di] : '0;

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      best_in   = best_ff;
      bd_in     = bd_ff;
      diff_in   = diff_ff;
      sq_in     = sq_ff;
      part_in   = part_ff;
      pbuf_in   = pbuf_ff;
      pval_in   = pval_ff;
      sval_in   = sval_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      neg_in    = neg_ff;
      empty_in  = empty_ff;
      nc_in     = nc_ff;
      rv_in     = rv_ff && !rsp_ready;
      rp_in     = rp_ff;
      cmd_pop   = 1'b0;
      cen_we    = 1'b0;
      cen_waddr = addr_cd;
      cen_wdata = nc_ff;
      cen_raddr = addr_cd;
      sum_we    = 1'b0;
      sum_waddr = addr_bd;
      sum_wdata = (sval_ff[addr_bd] ? sum_rdata : '0) + SW'(pv);
      sum_raddr = addr_cd;
      div_start = 1'b0;
      div_dividend = sval_rd[SW-1] ? SW'(-sval_rd) : sval_rd;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               item_in = cmd;
               c_in    = 3'd0;
               d_in    = 3'd0;
               if (cmd.load) begin
                  cen_we    = 1'b1;
                  cen_waddr = addr_of(cmd.center, cmd.dim);
                  cen_wdata = cmd.value;
               end else if (cmd.point) begin
                  // a new point drops whatever was left of the previous one
                  if (cmd.first) begin
                     pval_in = '0;
                     for (int i = 0; i < MAX_CENTERS; i++) part_in[i] = '0;
                  end
                  pval_in[cmd.dim[DIW-1:0]] = 1'b1;
                  pbuf_in[cmd.dim[DIW-1:0]] = cmd.value;
                  state_in = S_CRD;
               end else if (cmd.finish) begin
                  state_in = S_FRD;
               end
            end
         end
         S_CRD: begin
            cen_raddr = addr_ci;
            state_in  = S_DIFF;
         end
         S_DIFF: begin
            diff_in  = 17'(item_ff.value) - 17'($signed(cen_rdata));
            state_in = S_MUL;
         end
         S_MUL: begin
            sq_in    = 34'(diff_ff * diff_ff);
            state_in = S_ACC;
         end
         S_ACC: begin
            part_in[ci] = part_ff[ci] + DIST_W'(sq_ff);
            if (c_last) begin
               c_in     = 3'd0;
               state_in = item_ff.last_dim ? S_MIN : S_IDLE;
            end else begin
               c_in     = c_ff + 3'd1;
               state_in = S_CRD;
            end
         end
         S_MIN: begin
            bd_in = bd_new;
            if ((c_ff == 3'd0) || (part_ff[ci] < bd_ff)) best_in = c_ff;
            if (c_last) begin
               err_in   = err_sum[ERR_W] ? '1 : err_sum[ERR_W-1:0];
               d_in     = 3'd0;
               state_in = S_SRD;
            end else begin
               c_in = c_ff + 3'd1;
            end
         end
         S_SRD: begin
            sum_raddr = addr_bd;
            // full cluster: report but leave sums and count alone
            state_in  = (cnt_ff[bi] >= COUNT_MAX) ? S_EMIT : S_SWR;
         end
         S_SWR: begin
            sum_we           = 1'b1;
            sval_in[addr_bd] = 1'b1;
            if (d_last) begin
               cnt_in[bi] = cnt_ff[bi] + CW'(1);
               state_in   = S_EMIT;
            end else begin
               d_in     = d_ff + 3'd1;
               state_in = S_SRD;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rv_in               = 1'b1;
               rp_in               = '0;
               rp_in.kind          = KIND_POINT;
               rp_in.out_center    = best_ff;
               rp_in.min_distance  = bd_ff;
               rp_in.total_error   = err_ff;
               rp_in.last          = 1'b1;
               for (int i = 0; i < MAX_CENTERS; i++) part_in[i] = '0;
               state_in = S_IDLE;
            end
         end
         S_FRD: begin
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (cnt_ff[ci] == '0) begin
               empty_in = 1'b1;
               nc_in    = cen_rdata;
               state_in = S_FEMIT;
            end else begin
               empty_in  = 1'b0;
               neg_in    = sval_rd[SW-1];
               div_start = 1'b1;
               state_in  = S_FDIV;
            end
         end
         S_FDIV: begin
            if (div_done) begin
               nc_in     = quo_s[COORD_W-1:0];
               cen_we    = 1'b1;
               cen_wdata = quo_s[COORD_W-1:0];
               state_in  = S_FEMIT;
            end
         end
         S_FEMIT: begin
            if (out_free) begin
               rv_in               = 1'b1;
               rp_in               = '0;
               rp_in.kind          = KIND_CENTER;
               rp_in.out_center    = c_ff;
               rp_in.out_dim       = d_ff;
               rp_in.new_coord     = nc_ff;
               rp_in.empty_cluster = empty_ff;
               rp_in.total_error   = err_ff;
               rp_in.last          = c_last && d_last;
               if (d_last) begin
                  d_in     = 3'd0;
                  c_in     = c_ff + 3'd1;
                  state_in = c_last ? S_FCLR : S_FRD;
               end else begin
                  d_in     = d_ff + 3'd1;
                  state_in = S_FRD;
               end
            end
         end
         S_FCLR: begin
            sval_in = '0;
            err_in  = '0;
            for (int i = 0; i < MAX_CENTERS; i++) begin
               cnt_in[i]  = '0;
               part_in[i] = '0;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      best_ff  <= best_in;
      bd_ff    <= bd_in;
      diff_ff  <= diff_in;
      sq_ff    <= sq_in;
      pbuf_ff  <= pbuf_in;
      neg_ff   <= neg_in;
      empty_ff <= empty_in;
      nc_ff    <= nc_in;
      rp_ff    <= rp_in;
      if (reset) begin
         state_ff <= S_IDLE;
         c_ff     <= 3'd0;
         d_ff     <= 3'd0;
         pval_ff  <= '0;
         sval_ff  <= '0;
         err_ff   <= '0;
         rv_ff    <= 1'b0;
         for (int i = 0; i < MAX_CENTERS; i++) begin
            part_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         c_ff     <= c_in;
         d_ff     <= d_in;
         pval_ff  <= pval_in;
         sval_ff  <= sval_in;
         err_ff   <= err_in;
         rv_ff    <= rv_in;
         part_ff  <= part_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign rsp_valid   = rv_ff;
   assign rsp_payload = rp_ff;

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FCLR) |=> (err_ff == '0 && sval_ff == '0))
      else $error("finish did not clear the iteration state");

   a_point_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |=> (rv_ff && rp_ff.kind == KIND_POINT))
      else $error("point assignment beat not loaded");

   a_div_only_finish: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == S_FDIV && cnt_ff[ci] != '0))
      else $error("divider started outside the update pass");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWR) |-> (cnt_ff[bi] < COUNT_MAX))
      else $error("sum update on a full cluster");
endmodule
`default_nettype wire

@@ rtl/kmeans_assign_update_top.sv @@
// Top level of the k-means assign/update block.
// Load beat: stored in the center RAM. Point coordinate: the shared multiply-accumulate
// takes the centers in turn; the last coordinate adds the min search and the sum update.
// Finish: each coordinate of a non-empty cluster is divided by the bit-serial divider.
// Request queue of two commands and a result register decouple the two channels.
// Synchronous active-high reset clears control, counts, sums and error; no clearing pass.
`default_nettype none
module kmeans_assign_update_top #(
   parameter int MAX_CENTERS     = kau_pkg::DEF_MAX_CENTERS,
   parameter int MAX_DIMS        = kau_pkg::DEF_MAX_DIMS,
   parameter int MAX_POINTS_LOG2 = kau_pkg::DEF_MAX_POINTS_LOG2
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   kau_stream_if.sink                              req_bus,
   kau_stream_if.source                            rsp_bus,
   input  wire logic                               csr_wr_en,
   input  wire logic [kau_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [kau_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import kau_pkg::*;

   logic [3:0]      ncent_ff, ndims_ff;
   logic [3:0]      k_eff, nd_eff;
   logic            cmd_valid, cmd_pop, rv;
   cmd_type         cmd;
   req_payload_type req_pl;
   rsp_payload_type rsp_pl;

   always_ff @(posedge clock) begin
      if (reset) begin
         ncent_ff <= 4'(MAX_CENTERS);
         ndims_ff <= 4'(MAX_DIMS);
      end else if (csr_wr_en) begin
         if (csr_index == CSR_NUM_CENTERS) ncent_ff <= csr_wr_data;
         if (csr_index == CSR_NUM_DIMS)    ndims_ff <= csr_wr_data;
      end
   end

   // clamp register values into the supported range
   assign k_eff  = (ncent_ff == 4'd0) ? 4'd1 :
                   (int'(ncent_ff) > MAX_CENTERS) ? 4'(MAX_CENTERS) : ncent_ff;
   assign nd_eff = (ndims_ff == 4'd0) ? 4'd1 :
                   (int'(ndims_ff) > MAX_DIMS) ? 4'(MAX_DIMS) : ndims_ff;

   assign req_pl = req_bus.payload;

   kau_front #(.MAX_CENTERS(MAX_CENTERS), .MAX_DIMS(MAX_DIMS)) u_front (
      .clock(clock), .reset(reset), .nd_eff(nd_eff),
      .in_valid(req_bus.valid), .in_ready(req_bus.ready), .in_payload(req_pl),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
   );

   kau_core #(
      .MAX_CENTERS(MAX_CENTERS), .MAX_DIMS(MAX_DIMS), .MAX_POINTS_LOG2(MAX_POINTS_LOG2)
   ) u_core (
      .clock(clock), .reset(reset), .k_eff(k_eff), .nd_eff(nd_eff),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
      .rsp_valid(rv), .rsp_ready(rsp_bus.ready), .rsp_payload(rsp_pl)
   );

   assign rsp_bus.valid   = rv;
   assign rsp_bus.payload = rsp_pl;
endmodule
`default_nettype wire

@@ verif/kmeans_assign_update_top_test.sv @@
// Self-checking testbench for the k-means assign/update block with its own cluster predictor.
`default_nettype none
module kmeans_assign_update_top_test;
   import kau_pkg::*;

   localparam int  NC = DEF_MAX_CENTERS;
   localparam int  ND = DEF_MAX_DIMS;
   localparam int  QUIET_CYCLES = 300;
   localparam int  HOLD_CYCLES = 600;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam logic [DIST_W-1:0] DIST_ALL = '1;
   localparam logic [ERR_W-1:0]  ERR_SAT = '1;
   localparam int  COUNT_FULL = 1 << DEF_MAX_POINTS_LOG2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   kau_stream_if #(.payload_type(req_payload_type)) req_bus ();
   kau_stream_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   kmeans_assign_update_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state
   logic [3:0]                centers_reg = 4'd8;
   logic [3:0]                dims_reg = 4'd8;
   logic signed [COORD_W-1:0] center_mem [NC*ND];
   logic signed [COORD_W-1:0] point_coord [ND];
   logic [DIST_W-1:0]         dist_acc [NC];
   longint                    coord_sum [NC*ND];
   int                        members [NC];
   logic [ERR_W-1:0]          sse;

   req_payload_type pending_beats [$];
   rsp_payload_type expected_rsp [$];

   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   logic hold_req = 1'b0;
   int  hold_left;
   int  n_errors = 0;
   int  n_assign = 0;
   int  n_update = 0;
   int  n_empty = 0;
   longint cycles = 0;

   function automatic int clamp_cfg(logic [3:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic req_payload_type make_beat(logic [1:0] op, int ci, int di,
                                                 logic [COORD_W-1:0] v);
      req_payload_type b;
      b.op = op;
      b.center_index = ci[2:0];
      b.dim_index = di[2:0];
      b.coord_value = v;
      return b;
   endfunction

   task automatic clear_iteration();
      for (int i = 0; i < NC*ND; i++) coord_sum[i] = 0;
      for (int i = 0; i < NC; i++) begin
         members[i] = 0;
         dist_acc[i] = '0;
      end
      sse = '0;
   endtask

   // Apply one accepted beat to the cluster state and queue the results it causes
   task automatic cluster_step(req_payload_type b);
      int k;
      int nd;
      int best;
      int diff;
      longint mag;
      logic [DIST_W-1:0] best_dist;
      logic [ERR_W:0] err_sum;
      longint q;
      rsp_payload_type r;
      k = clamp_cfg(centers_reg, NC);
      nd = clamp_cfg(dims_reg, ND);
      case (b.op)
         OP_LOAD: begin
            center_mem[b.center_index*ND + b.dim_index] = b.coord_value;
         end
         OP_POINT: begin
            if (b.dim_index < nd) begin
               if (b.dim_index == 0) begin
                  for (int i = 0; i < ND; i++) point_coord[i] = '0;
                  for (int i = 0; i < NC; i++) dist_acc[i] = '0;
               end
               point_coord[b.dim_index] = b.coord_value;
               for (int c = 0; c < k; c++) begin
                  diff = int'(b.coord_value) - int'(center_mem[c*ND + b.dim_index]);
                  mag = (diff < 0) ? -diff : diff;
                  dist_acc[c] = (dist_acc[c] + DIST_W'(mag * mag)) & DIST_ALL;
               end
               if (b.dim_index == nd - 1) begin
                  best = 0;
                  best_dist = dist_acc[0];
                  for (int c = 1; c < k; c++) begin
                     if (dist_acc[c] < best_dist) begin
                        best_dist = dist_acc[c];
                        best = c;
                     end
                  end
                  if (members[best] < COUNT_FULL) begin
                     members[best]++;
                     for (int d = 0; d < nd; d++)
                        coord_sum[best*ND + d] += longint'(point_coord[d]);
                  end
                  err_sum = {1'b0, sse} + best_dist;
                  sse = err_sum[ERR_W] ? ERR_SAT : err_sum[ERR_W-1:0];
                  for (int i = 0; i < NC; i++) dist_acc[i] = '0;
                  r = '0;
                  r.kind = KIND_POINT;
                  r.out_center = best[2:0];
                  r.min_distance = best_dist;
                  r.total_error = sse;
                  r.last = 1'b1;
                  expected_rsp.push_back(r);
               end
            end
         end
         OP_FINISH: begin
            for (int c = 0; c < k; c++) begin
               for (int d = 0; d < nd; d++) begin
                  r = '0;
                  r.kind = KIND_CENTER;
                  r.out_center = c[2:0];
                  r.out_dim = d[2:0];
                  r.total_error = sse;
                  r.last = (c == k - 1) && (d == nd - 1);
                  if (members[c] == 0) begin
                     r.empty_cluster = 1'b1;
                     r.new_coord = center_mem[c*ND + d];
                  end else begin
                     q = coord_sum[c*ND + d] / longint'(members[c]);
                     center_mem[c*ND + d] = q[COORD_W-1:0];
                     r.new_coord = q[COORD_W-1:0];
                  end
                  expected_rsp.push_back(r);
               end
            end
            clear_iteration();
         end
         default: ;
      endcase
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.payload <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) cluster_step(req_bus.payload);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.payload <= pending_beats.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result ready, with an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_req && hold_left == 0) begin
         hold_left <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic flag_mismatch(string field, logic [63:0] exp_v, logic [63:0] act_v);
      n_errors++;
      if (n_errors <= 40)
         $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, field, exp_v, act_v);
   endtask

   // Result monitor
   always @(posedge clock) begin
      rsp_payload_type e;
      rsp_payload_type a;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         a = rsp_bus.payload;
         if (expected_rsp.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result beat %h", $time, a);
         end else begin
            e = expected_rsp.pop_front();
            if (a.kind !== e.kind) flag_mismatch("kind", e.kind, a.kind);
            if (a.out_center !== e.out_center)
               flag_mismatch("out_center", e.out_center, a.out_center);
            if (a.out_dim !== e.out_dim) flag_mismatch("out_dim", e.out_dim, a.out_dim);
            if (a.new_coord !== e.new_coord)
               flag_mismatch("new_coord", e.new_coord, a.new_coord);
            if (a.min_distance !== e.min_distance)
               flag_mismatch("min_distance", e.min_distance, a.min_distance);
            if (a.empty_cluster !== e.empty_cluster)
               flag_mismatch("empty_cluster", e.empty_cluster, a.empty_cluster);
            if (a.total_error !== e.total_error)
               flag_mismatch("total_error", e.total_error, a.total_error);
            if (a.last !== e.last) flag_mismatch("last", e.last, a.last);
            if (e.kind == KIND_POINT) n_assign++;
            else begin
               n_update++;
               if (e.empty_cluster) n_empty++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Write both geometry registers back to back; the block must be idle
   task automatic set_geometry(logic [3:0] k, logic [3:0] d);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_NUM_CENTERS;
      csr_wr_data <= k;
      @(posedge clock);
      csr_index <= CSR_NUM_DIMS;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      centers_reg = k;
      dims_reg = d;
   endtask

   task automatic drain();
      while (pending_beats.size() != 0 || req_bus.valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   // Well-formed points with random content, plus broken sequences and noise
   task automatic queue_random(int n_beats);
      int nd;
      int added;
      int sel;
      int cut;
      nd = clamp_cfg(dims_reg, ND);
      added = 0;
      while (added < n_beats) begin
         sel = $urandom_range(99);
         if (sel < 70) begin
            for (int d = 0; d < nd; d++) begin
               // drop an inner coordinate now and then
               if (d == 0 || d == nd - 1 || $urandom_range(9) != 0) begin
                  pending_beats.push_back(make_beat(OP_POINT, $urandom_range(7), d,
                                                    pick_coord()));
                  added++;
               end
            end
         end else if (sel < 77) begin
            cut = (nd > 1) ? $urandom_range(nd - 2) : 0;
            for (int d = 0; d <= cut && nd > 1; d++) begin
               pending_beats.push_back(make_beat(OP_POINT, 0, d, pick_coord()));
               added++;
            end
         end else if (sel < 83) begin
            pending_beats.push_back(make_beat(OP_LOAD, $urandom_range(7), $urandom_range(7),
                                              pick_coord()));
            added++;
         end else if (sel < 90) begin
            if (nd < ND && $urandom_range(1))
               pending_beats.push_back(make_beat(OP_POINT, $urandom_range(7),
                                                 $urandom_range(7, nd), pick_coord()));
            else
               pending_beats.push_back(make_beat(OP_UNUSED, $urandom_range(7),
                                                 $urandom_range(7), 16'($urandom)));
         end else begin
            pending_beats.push_back(make_beat(OP_FINISH, $urandom_range(7),
                                              $urandom_range(7), 16'($urandom)));
            added++;
         end
      end
      pending_beats.push_back(make_beat(OP_FINISH, 0, 0, 16'h0));
   endtask

   task automatic run_phase(logic [3:0] k, logic [3:0] d, int idle, int stall, int n_beats);
      set_geometry(k, d);
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      queue_random(n_beats);
      drain();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      for (int i = 0; i < NC*ND; i++) center_mem[i] = '0;
      for (int i = 0; i < ND; i++) point_coord[i] = '0;
      clear_iteration();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_geometry(4'd8, 4'd8);

      // Define every center coordinate before any distance is taken
      for (int c = 0; c < NC; c++)
         for (int d = 0; d < ND; d++)
            pending_beats.push_back(make_beat(OP_LOAD, c, d, pick_coord()));

      // Directed: extreme centers, extreme points, a broken point, an unused op, a finish
      for (int d = 0; d < ND; d++) begin
         pending_beats.push_back(make_beat(OP_LOAD, 0, d, 16'h7FFF));
         pending_beats.push_back(make_beat(OP_LOAD, 1, d, 16'h8000));
      end
      for (int d = 0; d < ND; d++)
         pending_beats.push_back(make_beat(OP_POINT, 0, d, 16'h8000));
      pending_beats.push_back(make_beat(OP_UNUSED, 7, 7, 16'hFFFF));
      for (int d = 0; d < 3; d++)
         pending_beats.push_back(make_beat(OP_POINT, 0, d, 16'h7FFF));
      for (int d = 0; d < ND; d++)
         pending_beats.push_back(make_beat(OP_POINT, 0, d, 16'h7FFF));
      pending_beats.push_back(make_beat(OP_FINISH, 0, 0, 16'h0));
      drain();
      // Two identical centers: the lower index must win
      set_geometry(4'd3, 4'd1);
      pending_beats.push_back(make_beat(OP_LOAD, 1, 0, 16'd100));
      pending_beats.push_back(make_beat(OP_LOAD, 2, 0, 16'd100));
      pending_beats.push_back(make_beat(OP_LOAD, 0, 0, -16'sd5000));
      pending_beats.push_back(make_beat(OP_POINT, 0, 0, 16'd100));
      pending_beats.push_back(make_beat(OP_POINT, 0, 0, -16'sd5001));
      pending_beats.push_back(make_beat(OP_POINT, 0, 0, -16'sd5002));
      pending_beats.push_back(make_beat(OP_FINISH, 0, 0, 16'h0));
      drain();

      run_phase(4'd8, 4'd8, 0, 0, 40);
      run_phase(4'd1, 4'd1, 49, 0, 30);
      run_phase(4'd0, 4'd0, 0, 49, 20);
      run_phase(4'd15, 4'd15, 37, 37, 40);
      run_phase(4'd3, 4'd5, 49, 0, 40);
      run_phase(4'd8, 4'd2, 0, 49, 40);
      run_phase(4'd5, 4'd8, 37, 37, 40);

      // Hold the result side off while points keep coming so the input stalls
      set_geometry(4'd4, 4'd3);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      queue_random(50);
      drain();

      run_phase(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)), 0, 0, 30);

      $display("Checked %0d point assignments and %0d center updates (%0d of an empty cluster)",
               n_assign, n_update, n_empty);
      $display("Geometries from 1x1 to 8x8, out-of-range register values, stalls on both sides");
      if (n_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/kau_pkg.sv
rtl/kau_stream_if.sv
rtl/kau_ram.sv
rtl/kau_front.sv
rtl/kau_div.sv
rtl/kau_core.sv
rtl/kmeans_assign_update_top.sv
verif/kmeans_assign_update_top_test.sv
